// ----- rtl/core/raf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// raf_pkg
// Shared types and constants of the speed-adaptive airflow filter.
// ----------------------------------------------------------------------------
package raf_pkg;

	// Field widths of the transactions and the register.
	localparam int SAMPLE_W = 20;
	localparam int SPEED_W  = 15;
	localparam int PARAM_W  = 16;
	localparam int PATH_W   = 2;

	// Default sample period in milliseconds.
	localparam int CALL_PERIOD_MS_DEF = 5;

	// The divisor is 1000 * filter_param, which stays below 2**26.
	localparam int DEN_MULT = 1000;
	localparam int DEN_W    = 26;

	// Alpha is Q0.16. The quotient keeps 17 bits so that values of one
	// and above are still seen; anything beyond is an overflow.
	localparam int QUOT_W = 17;
	// The dividend is period * speed * 2**24; the top part enters the
	// divider shifted by 24 - 17 bits.
	localparam int PRE_SHIFT = 7;
	localparam int CNT_W     = 5;

	localparam logic [QUOT_W-1:0] ALPHA_MIN = QUOT_W'(66);
	localparam logic [QUOT_W-1:0] ALPHA_MAX = QUOT_W'(64225);

	// Blend product: 18-bit signed alpha times 21-bit signed difference.
	localparam int FRAC_W = 16;
	localparam int PROD_W = 39;

	// Codes for the path a sample took.
	typedef enum logic [PATH_W-1:0] {
		PATH_DISABLED = 2'd0,
		PATH_STOPPED  = 2'd1,
		PATH_BYPASS   = 2'd2,
		PATH_FILTERED = 2'd3
	} raf_path_t;

	// Main sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ALPHA,
		ST_MUL,
		ST_ACC,
		ST_OUT
	} raf_state_t;

	// Divider sequencer states.
	typedef enum logic [1:0] {
		DV_IDLE,
		DV_CHK,
		DV_STEP
	} raf_div_state_t;

	// Status reported by the divider.
	typedef struct packed {
		logic              done;
		logic              ovf;
		logic [QUOT_W-1:0] quot;
	} raf_div_sts_t;

endpackage : raf_pkg
`default_nettype wire

// ----- rtl/core/raf_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// raf_if
// Valid/ready channels of the airflow filter: samples, results, register.
// ----------------------------------------------------------------------------

// Sample channel: raw airflow and engine speed.
interface raf_meas_if;
	import raf_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] airflow_sample;
	logic [SPEED_W-1:0]  engine_speed;
	modport source (output valid, output airflow_sample, output engine_speed, input ready);
	modport sink   (input valid, input airflow_sample, input engine_speed, output ready);
endinterface : raf_meas_if

// Result channel: filtered airflow and the path taken.
interface raf_filt_if;
	import raf_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] filtered_airflow;
	logic [PATH_W-1:0]   path_taken;
	modport source (output valid, output filtered_airflow, output path_taken, input ready);
	modport sink   (input valid, input filtered_airflow, input path_taken, output ready);
endinterface : raf_filt_if

// Register write channel: filter_param.
interface raf_cfg_if;
	import raf_pkg::*;
	logic               valid;
	logic               ready;
	logic [PARAM_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface : raf_cfg_if
`default_nettype wire

// ----- rtl/core/raf_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// raf_div
// Restoring divider for alpha: one shared subtractor, one quotient bit per
// cycle, with an up-front check for quotients of 2**17 and above.
// ----------------------------------------------------------------------------
module raf_div #(
	parameter int REM_W = 27
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire [REM_W-1:0]           num_hi,
	input  wire [raf_pkg::DEN_W-1:0]  den,
	output raf_pkg::raf_div_sts_t     sts
);
	import raf_pkg::*;

	raf_div_state_t      state_q;
	logic [REM_W-1:0]    rem_q;
	logic [DEN_W-1:0]    den_q;
	logic [QUOT_W-1:0]   quot_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	logic                ovf_q;
	logic [DEN_W+1:0]    trial;
	logic                fits;

	// Shared subtractor: shift the partial remainder and try the divisor.
	// The remainder is below the divisor here, so DEN_W bits hold it.
	assign trial = {1'b0, rem_q[DEN_W-1:0], 1'b0} - {2'b00, den_q};
	assign fits  = ~trial[DEN_W+1];

	// Sequencer and datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				DV_IDLE: begin
					if (start) begin
						state_q <= DV_CHK;
					end
				end
				DV_CHK: begin
					// A quotient of 2**17 or more is far above the bypass limit.
					if (rem_q >= REM_W'(den_q)) begin
						ovf_q   <= 1'b1;
						done_q  <= 1'b1;
						state_q <= DV_IDLE;
					end else begin
						ovf_q   <= 1'b0;
						cnt_q   <= CNT_W'(QUOT_W - 1);
						state_q <= DV_STEP;
					end
				end
				DV_STEP: begin
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= DV_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= DV_IDLE;
				end
			endcase
		end
	end

	// Operand and quotient registers.
	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && start) begin
			rem_q  <= num_hi;
			den_q  <= den;
			quot_q <= '0;
		end else if (state_q == DV_STEP) begin
			quot_q <= {quot_q[QUOT_W-2:0], fits};
			if (fits) begin
				rem_q <= REM_W'(trial[DEN_W:0]);
			end else begin
				rem_q <= REM_W'({rem_q[DEN_W-1:0], 1'b0});
			end
		end
	end

	assign sts = {done_q, ovf_q, quot_q};

endmodule : raf_div
`default_nettype wire

// ----- rtl/core/rpm_adaptive_airflow_filter_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rpm_adaptive_airflow_filter_unit
// Speed-adaptive exponential moving average of airflow samples.
// ----------------------------------------------------------------------------
// Usage:
// A sample transaction on meas carries one airflow reading and the engine
// speed; each one yields exactly one result transaction on filt with the
// filtered airflow and a code for the path taken. filter_param is written
// through cfg, which is always ready; write it only while no sample is
// in flight.
// A disabled filter or a stopped engine passes the sample straight to the
// output register. Otherwise alpha = period*rpm*256/(1000*param) is
// found by a restoring divider that yields one quotient bit per cycle
// after a range check; an alpha above ALPHA_MAX bypasses the filter,
// else one multiply and one add give the filtered result.
// meas is ready only while the sequencer is idle, so a new sample is
// taken only once the last result has moved to the output register.
// Reset clears filter_param and the stored filtered value to zero and
// empties the result register. A stalled receiver holds the result in the
// output register; the next sample is accepted meanwhile and waits at the
// end of its computation until that register is free.
// ----------------------------------------------------------------------------
module rpm_adaptive_airflow_filter_unit #(
	parameter int CALL_PERIOD_MS = raf_pkg::CALL_PERIOD_MS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	raf_meas_if.sink   meas,
	raf_filt_if.source filt,
	raf_cfg_if.sink    cfg
);
	import raf_pkg::*;

	// period * speed, and the divider remainder width that holds it shifted.
	localparam int PS_W  = $clog2(CALL_PERIOD_MS * ((1 << SPEED_W) - 1) + 1);
	localparam int NUM_W = PS_W + PRE_SHIFT;
	localparam int REM_W = (NUM_W > DEN_W + 1) ? NUM_W : DEN_W + 1;

	raf_state_t             state_q, state_d;
	logic [PARAM_W-1:0]     param_q;
	logic [SAMPLE_W-1:0]    last_q;
	logic [SAMPLE_W-1:0]    sample_q;
	logic [SAMPLE_W-1:0]    res_q;
	raf_path_t              path_q;
	logic [QUOT_W-1:0]      alpha_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                   out_valid_q;
	logic [SAMPLE_W-1:0]    out_flow_q;
	logic [PATH_W-1:0]      out_path_q;

	logic                   accept;
	logic                   div_start;
	logic                   out_load;
	logic [PS_W-1:0]        ps;
	logic [REM_W-1:0]       num_hi;
	logic [DEN_W-1:0]       den;
	raf_div_sts_t           div_sts;
	logic signed [SAMPLE_W:0] diff;
	logic signed [PROD_W-1:0] acc;

	// Register write channel.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			param_q <= '0;
		end else if (cfg.valid) begin
			param_q <= cfg.data;
		end
	end

	// Divider operands: dividend top part and divisor.
	assign ps     = PS_W'(CALL_PERIOD_MS) * PS_W'(meas.engine_speed);
	assign num_hi = REM_W'({ps, {PRE_SHIFT{1'b0}}});
	assign den    = DEN_W'(param_q) * DEN_W'(DEN_MULT);

	assign accept = meas.valid && meas.ready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || filt.ready);

	raf_div #(
		.REM_W (REM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_hi (num_hi),
		.den    (den),
		.sts    (div_sts)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d    = state_q;
		meas.ready = 1'b0;
		div_start  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				meas.ready = 1'b1;
				if (meas.valid) begin
					if (param_q == '0 || meas.engine_speed == '0) begin
						state_d = ST_OUT;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_sts.done) begin
					state_d = div_sts.ovf ? ST_OUT : ST_ALPHA;
				end
			end
			ST_ALPHA: begin
				state_d = (alpha_q > ALPHA_MAX) ? ST_OUT : ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Blend as last + alpha * (sample - last), all in Q.16.
	assign diff = $signed({1'b0, sample_q}) - $signed({1'b0, last_q});
	assign acc  = $signed(PROD_W'({last_q, {FRAC_W{1'b0}}})) + prod_q;

	// Stored filtered value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (accept && param_q != '0 && meas.engine_speed == '0) begin
			last_q <= meas.airflow_sample;
		end else if (state_q == ST_DIV && div_sts.done && div_sts.ovf) begin
			last_q <= sample_q;
		end else if (state_q == ST_ALPHA && alpha_q > ALPHA_MAX) begin
			last_q <= sample_q;
		end else if (state_q == ST_ACC) begin
			last_q <= acc[FRAC_W+SAMPLE_W-1:FRAC_W];
		end
	end

	// Working registers of one sample.
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= meas.airflow_sample;
			res_q    <= meas.airflow_sample;
			path_q   <= (param_q == '0) ? PATH_DISABLED : PATH_STOPPED;
		end
		if (state_q == ST_DIV && div_sts.done) begin
			path_q  <= PATH_BYPASS;
			alpha_q <= div_sts.quot;
		end
		if (state_q == ST_ALPHA && alpha_q < ALPHA_MIN) begin
			alpha_q <= ALPHA_MIN;
		end
		if (state_q == ST_MUL) begin
			prod_q <= $signed({1'b0, alpha_q}) * diff;
		end
		if (state_q == ST_ACC) begin
			res_q  <= acc[FRAC_W+SAMPLE_W-1:FRAC_W];
			path_q <= PATH_FILTERED;
		end
	end

	// Output register: holds a result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (filt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_flow_q <= res_q;
			out_path_q <= path_q;
		end
	end

	assign filt.valid            = out_valid_q;
	assign filt.filtered_airflow = out_flow_q;
	assign filt.path_taken       = out_path_q;

endmodule : rpm_adaptive_airflow_filter_unit
`default_nettype wire
